[hdl/seconds_to_calendar_date_assert.svh]
// Assertion macros used by the checker of the calendar date converter.
`ifndef SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

// Clocked property, held off while reset is asserted.
`define STCD_ASSERT(LBL, CLK, RSTN, PROP, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) else $error(MSG);

// Clocked property that is also checked through reset.
`define STCD_ASSERT_ALWAYS(LBL, CLK, PROP, MSG) \
  LBL: assert property (@(posedge CLK) PROP) else $error(MSG);

`endif

[hdl/stcd_pkg.sv]
`timescale 1ns / 1ps

package stcd_pkg;

  // Pipeline depth: one enable bit per register stage.
  localparam int STG_N = 7;
  typedef logic [STG_N-1:0] stg_en_t;

  // Field widths.
  localparam int SECS_W  = 32;
  localparam int DAYS_W  = 16;
  localparam int TOD_W   = 17;
  localparam int MINS_W  = 11;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W + WDAY_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Calendar constants.
  localparam int SECS_PER_DAY = 86400;
  localparam int SECS_PER_MIN = 60;
  localparam int JDN_EPOCH    = 2440588;
  localparam int JDN_SHIFT    = 32044;
  localparam int DAYS_400Y    = 146097;
  localparam int DAYS_4Y      = 1461;
  localparam int MONTH_SPAN   = 153;
  localparam int YEAR_OFS     = 4800;
  localparam int CENT_LO      = 67;   // lowest 400-year quarter count in range
  localparam int DAYS_WEEK    = 7;

  // Day of the March-based year on which month mm starts: (153*mm + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] mm);
    logic [8:0] res;
    case (mm)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

[hdl/stcd_daysplit.sv]
`timescale 1ns / 1ps

// Split seconds into whole days and seconds of the day (stages 1 and 2).
module stcd_daysplit (
  input  logic                        clk,
  input  logic [stcd_pkg::SECS_W-1:0] seconds,
  input  stcd_pkg::stg_en_t           en,
  output logic [stcd_pkg::DAYS_W-1:0] days,
  output logic [stcd_pkg::TOD_W-1:0]  tod
);
  import stcd_pkg::*;

  // 86400 = 2^7 * 675: shift off the low bits, divide the rest by 675.
  localparam int LO_W  = 7;
  localparam int HI_W  = SECS_W - LO_W;
  localparam int ODD   = SECS_PER_DAY >> LO_W;
  localparam int K     = 34;
  localparam int M_W   = 25;
  localparam logic [M_W-1:0] M = M_W'((64'd1 << K) / ODD);
  localparam int P_W   = HI_W + M_W;
  localparam int REM_W = 11;
  localparam int RED_W = TOD_W - LO_W;

  logic [P_W-1:0]    prod;
  logic [DAYS_W-1:0] q0_r;
  logic [HI_W-1:0]   hi_r;
  logic [LO_W-1:0]   lo_r;

  logic [HI_W-1:0]   rem_full;
  logic [REM_W-1:0]  rem;
  logic              fix;
  logic [DAYS_W-1:0] days_r;
  logic [RED_W-1:0]  red_r;
  logic [LO_W-1:0]   lo2_r;

  // Truncated reciprocal: the quotient estimate is exact or one low.
  assign prod = P_W'(seconds[SECS_W-1:LO_W]) * P_W'(M);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q0_r <= prod[K +: DAYS_W];
      hi_r <= seconds[SECS_W-1:LO_W];
      lo_r <= seconds[LO_W-1:0];
    end
  end

  assign rem_full = hi_r - HI_W'(q0_r) * HI_W'(ODD);
  assign rem      = rem_full[REM_W-1:0];
  assign fix      = (rem >= REM_W'(ODD));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      days_r <= q0_r + DAYS_W'(fix);
      red_r  <= fix ? RED_W'(rem - REM_W'(ODD)) : RED_W'(rem);
      lo2_r  <= lo_r;
    end
  end

  assign days = days_r;
  assign tod  = {red_r, lo2_r};

endmodule

[hdl/stcd_date.sv]
`timescale 1ns / 1ps

// Day count to Gregorian date and weekday (stages 3 to 7).
module stcd_date (
  input  logic                         clk,
  input  logic [stcd_pkg::DAYS_W-1:0]  days,
  input  stcd_pkg::stg_en_t            en,
  output logic [stcd_pkg::YEAR_W-1:0]  year,
  output logic [stcd_pkg::MONTH_W-1:0] month,
  output logic [stcd_pkg::DAY_W-1:0]   day,
  output logic [stcd_pkg::WDAY_W-1:0]  weekday
);
  import stcd_pkg::*;

  localparam int A_W   = 22;
  localparam int A_OFS = JDN_EPOCH + JDN_SHIFT;
  localparam int CQ0   = (CENT_LO * DAYS_400Y) / 4;
  localparam int CQ1   = ((CENT_LO + 1) * DAYS_400Y) / 4;
  localparam int CQ2   = ((CENT_LO + 2) * DAYS_400Y) / 4;
  localparam int TH1   = CQ1 - A_OFS;
  localparam int TH2   = CQ2 - A_OFS;
  localparam int DC_W  = 18;
  localparam int T_W   = DC_W + 2;
  localparam int YQ_W  = 9;
  localparam int K_Y   = 31;
  localparam int MY_W  = 21;
  localparam logic [MY_W-1:0] M_Y = MY_W'(((64'd1 << K_Y) + DAYS_4Y - 1) / DAYS_4Y);
  localparam int YD_W  = YQ_W + 11;
  localparam int DY_W  = 9;
  localparam int U_W   = 11;
  localparam int K_M   = 19;
  localparam int MM_MW = 12;
  localparam logic [MM_MW-1:0] M_M =
      MM_MW'(((64'd1 << K_M) + MONTH_SPAN - 1) / MONTH_SPAN);
  localparam int MM_W  = 4;
  localparam int WD_OFS = JDN_EPOCH % DAYS_WEEK;
  localparam int K_W   = 19;
  localparam int M7_W  = 17;
  localparam logic [M7_W-1:0] M_7 = M7_W'(((64'd1 << K_W) + DAYS_WEEK - 1) / DAYS_WEEK);
  localparam int WQ_W  = 13;

  // Stage 3: pick the 400-year quarter, reduce to a day within it.
  logic [1:0]        cent_nxt;
  logic [A_W-1:0]    a_w;
  logic [A_W-1:0]    dc_nxt;
  logic [1:0]        cent3_r;
  logic [DC_W-1:0]   dc3_r;

  // Every 32-bit input lands in one of three quarters.
  assign cent_nxt = (days >= DAYS_W'(TH2)) ? 2'd2 :
                    (days >= DAYS_W'(TH1)) ? 2'd1 : 2'd0;
  assign a_w      = A_W'(days) + A_W'(A_OFS);

  always_comb begin
    case (cent_nxt)
      2'd0:    dc_nxt = a_w - A_W'(CQ0);
      2'd1:    dc_nxt = a_w - A_W'(CQ1);
      2'd2:    dc_nxt = a_w - A_W'(CQ2);
      default: dc_nxt = a_w - A_W'(CQ0);
    endcase
  end

  // Weekday path, stage 3: quotient by 7 of the shifted day count.
  logic [DAYS_W-1:0]      wx;
  logic [DAYS_W+M7_W-1:0] wprod;
  logic [DAYS_W-1:0]      wx3_r;
  logic [WQ_W-1:0]        wq3_r;

  assign wx    = days + DAYS_W'(WD_OFS);
  assign wprod = (DAYS_W + M7_W)'(wx) * (DAYS_W + M7_W)'(M_7);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cent3_r <= cent_nxt;
      dc3_r   <= dc_nxt[DC_W-1:0];
      wx3_r   <= wx;
      wq3_r   <= wprod[K_W +: WQ_W];
    end
  end

  // Stage 4: year within the quarter, (4*dc + 3) / 1461.
  logic [T_W-1:0]       t_w;
  logic [T_W+MY_W-1:0]  yprod;
  logic [DAYS_W-1:0]    wrem;
  logic [1:0]           cent4_r;
  logic [DC_W-1:0]      dc4_r;
  logic [YQ_W-1:0]      yq4_r;
  logic [WDAY_W-1:0]    wd4_r;

  assign t_w   = {dc3_r, 2'b11};
  assign yprod = (T_W + MY_W)'(t_w) * (T_W + MY_W)'(M_Y);
  assign wrem  = wx3_r - DAYS_W'(wq3_r) * DAYS_W'(DAYS_WEEK);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cent4_r <= cent3_r;
      dc4_r   <= dc3_r;
      yq4_r   <= yprod[K_Y +: YQ_W];
      wd4_r   <= wrem[WDAY_W-1:0];
    end
  end

  // Stage 5: day of the March-based year.
  logic [YD_W-1:0]   ydays;
  logic [DC_W-1:0]   dy_full;
  logic [1:0]        cent5_r;
  logic [YQ_W-1:0]   yq5_r;
  logic [DY_W-1:0]   dy5_r;
  logic [WDAY_W-1:0] wd5_r;

  assign ydays   = YD_W'(yq4_r) * YD_W'(DAYS_4Y);
  assign dy_full = dc4_r - DC_W'(ydays >> 2);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      cent5_r <= cent4_r;
      yq5_r   <= yq4_r;
      dy5_r   <= dy_full[DY_W-1:0];
      wd5_r   <= wd4_r;
    end
  end

  // Stage 6: March-based month, (5*dy + 2) / 153.
  logic [U_W-1:0]       u_w;
  logic [U_W+MM_MW-1:0] mprod;
  logic [1:0]           cent6_r;
  logic [YQ_W-1:0]      yq6_r;
  logic [DY_W-1:0]      dy6_r;
  logic [MM_W-1:0]      mm6_r;
  logic [WDAY_W-1:0]    wd6_r;

  assign u_w   = (U_W'(dy5_r) << 2) + U_W'(dy5_r) + U_W'(2);
  assign mprod = (U_W + MM_MW)'(u_w) * (U_W + MM_MW)'(M_M);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      cent6_r <= cent5_r;
      yq6_r   <= yq5_r;
      dy6_r   <= dy5_r;
      mm6_r   <= mprod[K_M +: MM_W];
      wd6_r   <= wd5_r;
    end
  end

  // Stage 7: roll January and February into the next year, assemble the date.
  logic               roll;
  logic [DY_W-1:0]    mday_full;
  logic [YEAR_W-1:0]  ybase;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic [WDAY_W-1:0]  wd7_r;

  assign roll      = (mm6_r >= MM_W'(10));
  assign mday_full = dy6_r - month_start(mm6_r) + DY_W'(1);

  always_comb begin
    case (cent6_r)
      2'd0:    ybase = YEAR_W'(100 * CENT_LO - YEAR_OFS);
      2'd1:    ybase = YEAR_W'(100 * (CENT_LO + 1) - YEAR_OFS);
      2'd2:    ybase = YEAR_W'(100 * (CENT_LO + 2) - YEAR_OFS);
      default: ybase = YEAR_W'(100 * CENT_LO - YEAR_OFS);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      year_r  <= ybase + YEAR_W'(yq6_r) + YEAR_W'(roll);
      month_r <= roll ? MONTH_W'(mm6_r - MM_W'(9)) : MONTH_W'(mm6_r + MM_W'(3));
      day_r   <= mday_full[DAY_W-1:0];
      wd7_r   <= wd6_r;
    end
  end

  assign year    = year_r;
  assign month   = month_r;
  assign day     = day_r;
  assign weekday = wd7_r;

endmodule

[hdl/stcd_tod.sv]
`timescale 1ns / 1ps

// Seconds of the day to hour, minute and second (stages 3 to 7).
module stcd_tod (
  input  logic                        clk,
  input  logic [stcd_pkg::TOD_W-1:0]  tod,
  input  stcd_pkg::stg_en_t           en,
  output logic [stcd_pkg::HOUR_W-1:0] hour,
  output logic [stcd_pkg::MIN_W-1:0]  minute,
  output logic [stcd_pkg::SEC_W-1:0]  second
);
  import stcd_pkg::*;

  localparam int K_MIN = 24;
  localparam int MM_W  = 19;
  localparam logic [MM_W-1:0] M_MIN =
      MM_W'(((64'd1 << K_MIN) + SECS_PER_MIN - 1) / SECS_PER_MIN);
  localparam int K_HR  = 17;
  localparam int MH_W  = 12;
  localparam logic [MH_W-1:0] M_HR =
      MH_W'(((64'd1 << K_HR) + SECS_PER_MIN - 1) / SECS_PER_MIN);

  // Stage 3: minutes of the day.
  logic [TOD_W+MM_W-1:0] pmin;
  logic [MINS_W-1:0]     mins3_r;
  logic [TOD_W-1:0]      tod3_r;

  assign pmin = (TOD_W + MM_W)'(tod) * (TOD_W + MM_W)'(M_MIN);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mins3_r <= pmin[K_MIN +: MINS_W];
      tod3_r  <= tod;
    end
  end

  // Stage 4: second of the minute and hour of the day.
  logic [TOD_W-1:0]       sec_full;
  logic [MINS_W+MH_W-1:0] phr;
  logic [MINS_W-1:0]      mins4_r;
  logic [HOUR_W-1:0]      hour4_r;
  logic [SEC_W-1:0]       sec4_r;

  assign sec_full = tod3_r - TOD_W'(mins3_r) * TOD_W'(SECS_PER_MIN);
  assign phr      = (MINS_W + MH_W)'(mins3_r) * (MINS_W + MH_W)'(M_HR);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mins4_r <= mins3_r;
      hour4_r <= phr[K_HR +: HOUR_W];
      sec4_r  <= sec_full[SEC_W-1:0];
    end
  end

  // Stage 5: minute of the hour.
  logic [MINS_W-1:0] min_full;
  logic [HOUR_W-1:0] hour5_r;
  logic [MIN_W-1:0]  min5_r;
  logic [SEC_W-1:0]  sec5_r;

  assign min_full = mins4_r - MINS_W'(hour4_r) * MINS_W'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hour5_r <= hour4_r;
      min5_r  <= min_full[MIN_W-1:0];
      sec5_r  <= sec4_r;
    end
  end

  // Stages 6 and 7: hold alignment with the date path.
  logic [HOUR_W-1:0] hour6_r;
  logic [MIN_W-1:0]  min6_r;
  logic [SEC_W-1:0]  sec6_r;
  logic [HOUR_W-1:0] hour7_r;
  logic [MIN_W-1:0]  min7_r;
  logic [SEC_W-1:0]  sec7_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      hour6_r <= hour5_r;
      min6_r  <= min5_r;
      sec6_r  <= sec5_r;
    end
    if (en[6]) begin
      hour7_r <= hour6_r;
      min7_r  <= min6_r;
      sec7_r  <= sec6_r;
    end
  end

  assign hour   = hour7_r;
  assign minute = min7_r;
  assign second = sec7_r;

endmodule

[hdl/seconds_to_calendar_date.sv]
`timescale 1ns / 1ps

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date (year, month, day), the time of day (hour, minute, second)
// and the weekday (0 = Monday .. 6 = Sunday). Every 32-bit value converts;
// the top of the range is 2106-02-07 06:28:15. The block keeps no state:
// each input transaction gives exactly one output transaction, in order.
// It is a seven-stage pipeline; while the output side is ready, a new
// transaction is accepted every cycle. Each stage has its own valid bit
// and moves when the stage after it is empty or moving, so bubbles close
// up behind a stalled output and input keeps flowing until the pipeline
// is full. The pipeline depth is set by the multiplier chain of the date
// path: day split, quarter select, year, day of year, month, final
// assembly.
module seconds_to_calendar_date (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [stcd_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] seconds
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [11:0] year, [15:12] month, [20:16] day, [25:21] hour, [31:26] minute,
  // [37:32] second, [40:38] weekday, [47:41] zero
  output logic [stcd_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import stcd_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

  // Stage handshake: rdy[i] says stage i may load this cycle.
  logic [STG_N-1:0] v_r;
  logic [STG_N-1:0] v_nxt;
  logic [STG_N:0]   rdy;
  logic [STG_N-1:0] up_v;
  stg_en_t          en;

  assign rdy[STG_N] = out_tready;

  for (genvar g = 0; g < STG_N; g++) begin : g_stg
    // A stage can take new data when empty or when its content moves on.
    assign rdy[g] = ~v_r[g] | rdy[g+1];
  end

  assign up_v = {v_r[STG_N-2:0], in_tvalid};
  assign en   = up_v & rdy[STG_N-1:0];

  always_comb begin
    for (int i = 0; i < STG_N; i++) begin
      // Load the upstream valid when the stage advances, otherwise hold.
      v_nxt[i] = rdy[i] ? up_v[i] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[STG_N-1];

  // Datapath
  logic [DAYS_W-1:0]  days;
  logic [TOD_W-1:0]   tod;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [WDAY_W-1:0]  weekday;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;

  stcd_daysplit u_split (
    .clk     (clk),
    .seconds (in_tdata[SECS_W-1:0]),
    .en      (en),
    .days    (days),
    .tod     (tod)
  );

  stcd_date u_date (
    .clk     (clk),
    .days    (days),
    .en      (en),
    .year    (year),
    .month   (month),
    .day     (day),
    .weekday (weekday)
  );

  stcd_tod u_tod (
    .clk    (clk),
    .tod    (tod),
    .en     (en),
    .hour   (hour),
    .minute (minute),
    .second (second)
  );

  // Pack the result fields, lowest field in the lowest bits.
  assign out_tdata = {{PAD_W{1'b0}}, weekday, second, minute, hour, day, month, year};

endmodule

[hdl/stcd_chk.sv]
`timescale 1ns / 1ps
`include "seconds_to_calendar_date_assert.svh"

// Port-level checks of the calendar date converter.
module stcd_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [stcd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  `STCD_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Reset empties the pipeline.
  `STCD_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result valid right after reset")

  // With the output stage free, the pipeline has room for new input.
  `STCD_ASSERT(a_ready_free, clk, rst_n, (!out_tvalid || out_tready) |-> in_tready, "input blocked while output side is free")

  // Month, hour, minute, second and weekday lie in their calendar ranges, day is nonzero and the pad bits are clear.
  `STCD_ASSERT(a_fields, clk, rst_n, out_tvalid |-> out_tdata[15:12] != 4'd0 && out_tdata[15:12] <= 4'd12 && out_tdata[20:16] != 5'd0 && out_tdata[25:21] <= 5'd23 && out_tdata[31:26] <= 6'd59 && out_tdata[37:32] <= 6'd59 && out_tdata[40:38] <= 3'd6 && out_tdata[47:41] == 7'd0, "result field out of range")

  // in_tvalid is part of the port set watched here; an offered transaction is
  // always taken at once when the output side is ready.
  `STCD_ASSERT(a_take, clk, rst_n, in_tvalid && out_tready |-> in_tready, "offered input not taken with output ready")

endmodule

bind seconds_to_calendar_date stcd_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import stcd_pkg::*;

  // Run bounds: the cycle limit lies far above the slowest correct run of
  // roughly 1200 items.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4 * STG_N;
  localparam int RANDOM_ITEMS = 1150;
  localparam int LAST_FULL_DAY = 49709;  // last day that fits whole in 32 bits

  // One converted timestamp, at the widths of the result fields.
  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [WDAY_W-1:0]  weekday;
  } calendar_t;

  // Holds the dates expected from accepted timestamps, oldest first, and
  // compares each result transaction against the head of the queue.
  class calendar_scoreboard;
    calendar_t pending_dates[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Split seconds into days and time of day, turn the day count into a
    // Julian day number, then run the integer Julian-day-to-civil steps.
    function calendar_t to_calendar(logic [SECS_W-1:0] secs);
      longint unsigned s, days, tod, jdn, a, cent, dc, yq, dy, mm, roll;
      calendar_t res;
      s    = secs;
      days = s / SECS_PER_DAY;
      tod  = s % SECS_PER_DAY;
      jdn  = days + JDN_EPOCH;
      a    = jdn + JDN_SHIFT;
      cent = (4 * a + 3) / DAYS_400Y;
      dc   = a - (DAYS_400Y * cent) / 4;
      yq   = (4 * dc + 3) / DAYS_4Y;
      dy   = dc - (DAYS_4Y * yq) / 4;
      mm   = (5 * dy + 2) / MONTH_SPAN;
      roll = mm / 10;
      res.year    = YEAR_W'(100 * cent + yq + roll - YEAR_OFS);
      res.month   = MONTH_W'(mm + 3 - 12 * roll);
      res.day     = DAY_W'(dy - (MONTH_SPAN * mm + 2) / 5 + 1);
      res.hour    = HOUR_W'(tod / 3600);
      res.minute  = MIN_W'((tod / 60) % 60);
      res.second  = SEC_W'(tod % 60);
      res.weekday = WDAY_W'(jdn % DAYS_WEEK);
      return res;
    endfunction

    function void note_timestamp(logic [SECS_W-1:0] secs);
      pending_dates.push_back(to_calendar(secs));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_date(logic [OUT_TDATA_W-1:0] tdata);
      calendar_t want;
      if (pending_dates.size() == 0) begin
        $error("result transaction with no timestamp pending: %h", tdata);
        errors++;
        return;
      end
      want = pending_dates.pop_front();
      compare_field("year",    16'(want.year),    16'(tdata[11:0]));
      compare_field("month",   16'(want.month),   16'(tdata[15:12]));
      compare_field("day",     16'(want.day),     16'(tdata[20:16]));
      compare_field("hour",    16'(want.hour),    16'(tdata[25:21]));
      compare_field("minute",  16'(want.minute),  16'(tdata[31:26]));
      compare_field("second",  16'(want.second),  16'(tdata[37:32]));
      compare_field("weekday", 16'(want.weekday), 16'(tdata[40:38]));
    endfunction

    function int outstanding();
      return pending_dates.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [31:0] seconds
  logic                   out_tvalid;
  logic                   out_tready;
  // [11:0] year, [15:12] month, [20:16] day, [25:21] hour, [31:26] minute,
  // [37:32] second, [40:38] weekday, [47:41] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  calendar_scoreboard dates = new();
  int                 cycle_count;

  seconds_to_calendar_date dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly back-to-back or short idles, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one timestamp: hold tvalid low for the gap, then hold the
  // transaction until the block takes it. Enter and leave on a falling edge.
  task automatic send_timestamp(input logic [SECS_W-1:0] secs, input int gap);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = secs;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Pick a random timestamp, weighted toward day boundaries and the top of
  // the range where the date arithmetic is most likely to slip.
  function automatic logic [SECS_W-1:0] random_timestamp();
    longint unsigned day_start;
    int              kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) return $urandom;
    if (kind < 75) begin
      day_start = longint'($urandom_range(0, LAST_FULL_DAY)) * SECS_PER_DAY;
      case ($urandom_range(0, 4))
        0:       return SECS_W'(day_start);
        1:       return SECS_W'(day_start + 1);
        2:       return SECS_W'(day_start + SECS_PER_DAY - 1);
        3:       return SECS_W'(day_start + SECS_PER_DAY - 2);
        default: return SECS_W'(day_start + $urandom_range(0, SECS_PER_DAY - 1));
      endcase
    end
    if (kind < 88) return 32'hFFFF_FFFF - $urandom_range(0, 200000);
    return $urandom_range(0, 32'h0010_0000);
  endfunction

  // Note every accepted timestamp and check every accepted date.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) dates.note_timestamp(in_tdata);
    if (rst_n && out_tvalid && out_tready) dates.check_date(out_tdata);
  end

  // Backpressure on the result side: ready runs broken by stalls, with an
  // occasional long stretch of steady ready.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      out_tready = 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(60, 200)) @(negedge clk);
      else repeat ($urandom_range(1, 12)) @(negedge clk);
      out_tready = 1'b0;
      repeat ($urandom_range(1, 1 + idle_cycles())) @(negedge clk);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("seconds_to_calendar_date: mismatch");
    $finish;
  end

  initial begin
    logic [SECS_W-1:0] corner_secs[$];
    int                gap;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Epoch, top of the range, day/month/year edges, leap days in 1972 and
    // 2000, the non-leap end of February 2100, and bit patterns that toggle
    // every input bit.
    corner_secs = '{32'd0, 32'hFFFF_FFFF, 32'd86399, 32'd86400,
                    32'd2678399, 32'd2678400, 32'd68083199, 32'd68169600,
                    32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
                    32'd4102444799, 32'd4102444800, 32'd4107542399,
                    32'd4107542400, 32'd4294944000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
    foreach (corner_secs[i]) send_timestamp(corner_secs[i], idle_cycles());

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Every fourth block of 100 transactions goes back to back.
      gap = ((i / 100) % 4 == 3) ? 0 : idle_cycles();
      send_timestamp(random_timestamp(), gap);
    end
    in_tvalid = 1'b0;

    // Drain the pipeline, then give stray results time to show up.
    while (dates.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (dates.errors == 0 && dates.outstanding() == 0) begin
      $display("seconds_to_calendar_date: match");
    end else begin
      $display("seconds_to_calendar_date: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/stcd_pkg.sv
hdl/stcd_daysplit.sv
hdl/stcd_date.sv
hdl/stcd_tod.sv
hdl/seconds_to_calendar_date.sv
hdl/stcd_chk.sv
tb/sv/tb_top.sv
